// ===== sv/binary_gcd_core_assert.svh =====
// ----------------------------------------------------------------------------
// binary gcd core assertion macros
// clocked concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef BINARY_GCD_CORE_ASSERT_SVH
`define BINARY_GCD_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BGCD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BGCD_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BGCD_ASSERT(label, clk, rst, prop, msg)
`define BGCD_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

// ===== sv/bgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bgcd_pkg
// shared constants and types for the binary gcd core
// ----------------------------------------------------------------------------
package bgcd_pkg;

  localparam int DATA_W    = 32;
  localparam int DEF_WIDTH = 32;

  typedef logic [2:0] cell_op_t;

  localparam cell_op_t OP_HOLD   = 3'd0;
  localparam cell_op_t OP_LOAD   = 3'd1;
  localparam cell_op_t OP_SHR_AB = 3'd2;
  localparam cell_op_t OP_SHR_A  = 3'd3;
  localparam cell_op_t OP_SHR_B  = 3'd4;
  localparam cell_op_t OP_SUB    = 3'd5;
  localparam cell_op_t OP_SHL_A  = 3'd6;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic a_odd;
    logic b_odd;
  } chain_status_t;

endpackage

// ===== sv/binary_gcd_core.sv =====
// ----------------------------------------------------------------------------
// binary_gcd_core
// greatest common divisor of two unsigned operands by the binary method
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_ready with first_operand and second_operand;
//   an item is taken when both are high. in_ready is high while the core is
//   idle, including while a finished divisor waits in the output register.
//   output channel: out_valid / out_ready with divisor, one result per item.
//   sequence: a load, a zero check, a halving of both operands per common
//   factor of two, a halving of a per stripped trailing zero, subtract-halve
//   or halve steps, a restoring left shift per common factor, then posting
//   of the result; a zero operand goes from the zero check straight to the
//   post. a new item is taken only once the previous one has been posted;
//   the row of bit cells does one shift or subtract-halve step per cycle.
//   reset: returns to idle with no result pending; operand cells keep their
//   contents, which are reloaded by the next item.
//   stall: a held result keeps divisor steady; a finished item whose result
//   cannot enter the output register waits in the core until out_ready.
// ----------------------------------------------------------------------------
module binary_gcd_core
  import bgcd_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] first_operand,
  input  logic [DATA_W-1:0] second_operand,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] divisor
);

`include "binary_gcd_core_assert.svh"

  localparam int EXT_W = (WIDTH > DATA_W) ? WIDTH : DATA_W;
  localparam int TW_W  = $clog2(WIDTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_TWOS  = 3'd2;
  localparam logic [2:0] ST_AODD  = 3'd3;
  localparam logic [2:0] ST_LOOP  = 3'd4;
  localparam logic [2:0] ST_SHIFT = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [TW_W-1:0]  twos;
  logic [TW_W-1:0]  twos_next;
  logic             zero_case;
  logic             zero_case_next;
  cell_op_t         op;
  chain_status_t    status;
  logic [WIDTH-1:0] a_bits;
  logic [WIDTH-1:0] b_bits;
  logic [EXT_W-1:0] first_ext;
  logic [EXT_W-1:0] second_ext;
  logic [WIDTH-1:0] res_w;
  logic [EXT_W-1:0] res_ext;
  logic             post;

  assign first_ext  = EXT_W'(first_operand);
  assign second_ext = EXT_W'(second_operand);
  assign res_w      = zero_case ? (a_bits | b_bits) : a_bits;
  assign res_ext    = EXT_W'(res_w);
  assign in_ready   = (state == ST_IDLE);
  assign post       = (state == ST_DONE) && (!out_valid || out_ready);

  bgcd_chain #(
    .WIDTH (WIDTH)
  ) u_chain (
    .clk    (clk),
    .op     (op),
    .load_a (first_ext[WIDTH-1:0]),
    .load_b (second_ext[WIDTH-1:0]),
    .a_bits (a_bits),
    .b_bits (b_bits),
    .status (status)
  );

  always_comb begin
    state_next     = state;
    twos_next      = twos;
    zero_case_next = zero_case;
    op             = OP_HOLD;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op             = OP_LOAD;
          twos_next      = '0;
          zero_case_next = 1'b0;
          state_next     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.a_zero || status.b_zero) begin
          zero_case_next = 1'b1;
          state_next     = ST_DONE;
        end else begin
          state_next = ST_TWOS;
        end
      end
      ST_TWOS: begin
        if (!status.a_odd && !status.b_odd) begin
          op        = OP_SHR_AB;
          twos_next = twos + 1'b1;
        end else begin
          state_next = ST_AODD;
        end
      end
      ST_AODD: begin
        if (!status.a_odd) begin
          op = OP_SHR_A;
        end else begin
          state_next = ST_LOOP;
        end
      end
      ST_LOOP: begin
        priority if (status.b_zero) begin
          state_next = ST_SHIFT;
        end else if (!status.b_odd) begin
          op = OP_SHR_B;
        end else begin
          op = OP_SUB;
        end
      end
      ST_SHIFT: begin
        if (twos != '0) begin
          op        = OP_SHL_A;
          twos_next = twos - 1'b1;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (post) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      twos      <= '0;
      zero_case <= 1'b0;
    end else begin
      state     <= state_next;
      twos      <= twos_next;
      zero_case <= zero_case_next;
      if (post) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      divisor <= res_ext[DATA_W-1:0];
    end
  end

  `BGCD_ASSERT(a_accept_leaves_idle, clk, rst,
    (in_valid && in_ready) |=> (state == ST_CHECK), "accepted item did not start")
  `BGCD_ASSERT(a_loop_a_odd, clk, rst,
    (state == ST_LOOP) |-> a_bits[0], "a is even inside the subtract loop")
  `BGCD_ASSERT(a_shift_count, clk, rst,
    (state == ST_SHIFT && twos != '0) |=> (twos == $past(twos) - 1'b1),
    "shift count did not step down")
  `BGCD_ASSERT(a_post_sets_valid, clk, rst, post |=> out_valid, "finished item not posted")

endmodule

// ===== sv/bgcd_cell.sv =====
// ----------------------------------------------------------------------------
// bgcd_cell
// one bit slice of the operand pair with subtract and shift steering
// ----------------------------------------------------------------------------
module bgcd_cell
  import bgcd_pkg::*;
(
  input  logic     clk,
  input  cell_op_t op,
  input  logic     a_lt_b,
  input  logic     load_a,
  input  logic     load_b,
  input  logic     a_hi,
  input  logic     b_hi,
  input  logic     a_lo,
  input  logic     dab_hi,
  input  logic     dba_hi,
  input  logic     bab_in,
  input  logic     bba_in,
  output logic     a,
  output logic     b,
  output logic     dab,
  output logic     dba,
  output logic     bab_out,
  output logic     bba_out
);

  logic a_next;
  logic b_next;

  // a - b and b - a bit slices
  assign dab     = a ^ b ^ bab_in;
  assign bab_out = (~a & b) | (~(a ^ b) & bab_in);
  assign dba     = a ^ b ^ bba_in;
  assign bba_out = (a & ~b) | (~(a ^ b) & bba_in);

  always_comb begin
    a_next = a;
    b_next = b;
    unique case (op)
      OP_LOAD: begin
        a_next = load_a;
        b_next = load_b;
      end
      OP_SHR_AB: begin
        a_next = a_hi;
        b_next = b_hi;
      end
      OP_SHR_A: a_next = a_hi;
      OP_SHR_B: b_next = b_hi;
      OP_SUB: begin
        if (a_lt_b) begin
          b_next = dba_hi;
        end else begin
          a_next = b;
          b_next = dab_hi;
        end
      end
      OP_SHL_A: a_next = a_lo;
      default: begin
        a_next = a;
        b_next = b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a <= a_next;
    b <= b_next;
  end

endmodule

// ===== sv/bgcd_chain.sv =====
// ----------------------------------------------------------------------------
// bgcd_chain
// row of bit cells linked by shift paths and borrow chains
// ----------------------------------------------------------------------------
module bgcd_chain
  import bgcd_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic             clk,
  input  cell_op_t         op,
  input  logic [WIDTH-1:0] load_a,
  input  logic [WIDTH-1:0] load_b,
  output logic [WIDTH-1:0] a_bits,
  output logic [WIDTH-1:0] b_bits,
  output chain_status_t    status
);

  logic [WIDTH-1:0] dab;
  logic [WIDTH-1:0] dba;
  logic [WIDTH:0]   bab;
  logic [WIDTH:0]   bba;
  logic [WIDTH-1:0] a_shr;
  logic [WIDTH-1:0] b_shr;
  logic [WIDTH-1:0] a_shl;
  logic [WIDTH-1:0] dab_shr;
  logic [WIDTH-1:0] dba_shr;
  logic             a_lt_b;

  assign bab[0]  = 1'b0;
  assign bba[0]  = 1'b0;
  assign a_lt_b  = bab[WIDTH];
  assign a_shr   = {1'b0, a_bits[WIDTH-1:1]};
  assign b_shr   = {1'b0, b_bits[WIDTH-1:1]};
  assign a_shl   = {a_bits[WIDTH-2:0], 1'b0};
  assign dab_shr = {1'b0, dab[WIDTH-1:1]};
  assign dba_shr = {1'b0, dba[WIDTH-1:1]};

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    bgcd_cell u_cell (
      .clk     (clk),
      .op      (op),
      .a_lt_b  (a_lt_b),
      .load_a  (load_a[i]),
      .load_b  (load_b[i]),
      .a_hi    (a_shr[i]),
      .b_hi    (b_shr[i]),
      .a_lo    (a_shl[i]),
      .dab_hi  (dab_shr[i]),
      .dba_hi  (dba_shr[i]),
      .bab_in  (bab[i]),
      .bba_in  (bba[i]),
      .a       (a_bits[i]),
      .b       (b_bits[i]),
      .dab     (dab[i]),
      .dba     (dba[i]),
      .bab_out (bab[i+1]),
      .bba_out (bba[i+1])
    );
  end

  assign status.a_zero = ~|a_bits;
  assign status.b_zero = ~|b_bits;
  assign status.a_odd  = a_bits[0];
  assign status.b_odd  = b_bits[0];

endmodule

// ===== verif/tb_binary_gcd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_gcd_core
// self-checking bench for the binary gcd core: directed edge operands, then
// random pairs biased toward shared factors, large factors of two, zeros and equal
// values; random gaps on the input side and stalls on the output side; every
// divisor is checked in order against a bench-side binary gcd
// ----------------------------------------------------------------------------
module tb_binary_gcd_core;
  import bgcd_pkg::*;

  localparam int RANDOM_PAIRS = 600;
  localparam int DRAIN_CYCLES = 4 * DEF_WIDTH + 20;
  localparam int STUCK_LIMIT  = 2000;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct {
    word_t       a;
    word_t       b;
    int unsigned gap;
  } pair_t;

  typedef struct {
    word_t a;
    word_t b;
    word_t gcd;
  } gcd_expect_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  word_t first_operand = '0;
  word_t second_operand = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  word_t divisor;

  pair_t       pair_q[$];
  gcd_expect_t gcd_expect_q[$];
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          steady_sink = 1'b0;
  int unsigned stuck_cycles = 0;

  binary_gcd_core u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .first_operand  (first_operand),
    .second_operand (second_operand),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .divisor        (divisor)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic word_t stein_gcd(input word_t x, input word_t y);
    word_t       u;
    word_t       v;
    word_t       diff;
    int unsigned shift;
    if (x == '0 || y == '0) begin
      return x | y;
    end
    u = x;
    v = y;
    shift = 0;
    while (u[0] == 1'b0 && v[0] == 1'b0) begin
      u = u >> 1;
      v = v >> 1;
      shift++;
    end
    while (u[0] == 1'b0) begin
      u = u >> 1;
    end
    do begin
      while (v[0] == 1'b0) begin
        v = v >> 1;
      end
      if (u < v) begin
        v = v - u;
      end else begin
        diff = u - v;
        u = v;
        v = diff;
      end
      v = v >> 1;
    end while (v != '0);
    return u << shift;
  endfunction

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 40) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 20);
    end
    return $urandom_range(40, 150);
  endfunction

  function automatic word_t pow2_heavy();
    return word_t'($urandom) << $urandom_range(0, DATA_W - 1);
  endfunction

  task automatic push_pair(input word_t a, input word_t b, input bit quiet);
    pair_t p;
    p.a = a;
    p.b = b;
    p.gap = pick_gap(quiet);
    pair_q.push_back(p);
  endtask

  task automatic report_mismatch(input string what, input gcd_expect_t e, input word_t got);
    $display("%0t: %s a=%h b=%h got %h want %h", $realtime, what, e.a, e.b, got, e.gcd);
    mismatches++;
  endtask

  // input driver
  always @(posedge clk) begin
    pair_t       p;
    gcd_expect_t e;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        e.a = first_operand;
        e.b = second_operand;
        e.gcd = stein_gcd(first_operand, second_operand);
        gcd_expect_q.push_back(e);
      end
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pair_q.size() != 0) begin
        p = pair_q.pop_front();
        first_operand <= p.a;
        second_operand <= p.b;
        in_valid <= 1'b1;
        send_gap <= p.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and output stalls
  always @(posedge clk) begin
    gcd_expect_t e;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      steady_sink <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (gcd_expect_q.size() == 0) begin
          e.a = 'x;
          e.b = 'x;
          e.gcd = 'x;
          report_mismatch("unexpected divisor", e, divisor);
        end else begin
          e = gcd_expect_q.pop_front();
          if (divisor !== e.gcd) begin
            report_mismatch("divisor mismatch", e, divisor);
          end
        end
      end
      if ($urandom_range(0, 599) == 0) begin
        steady_sink <= !steady_sink;
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!steady_sink && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall_left <= pick_gap(1'b0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, STUCK_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int unsigned r;
    bit          quiet;
    word_t       g;
    word_t       a;
    word_t       b;

    // directed
    push_pair('0, '0, 1'b0);
    push_pair('0, '1, 1'b0);
    push_pair('1, '0, 1'b0);
    push_pair('1, '1, 1'b0);
    push_pair(32'd1, 32'd1, 1'b0);
    push_pair(32'd1, '1, 1'b0);
    push_pair('1, 32'hFFFF_FFFE, 1'b0);
    push_pair(32'h8000_0000, 32'h8000_0000, 1'b0);
    push_pair(32'h8000_0000, 32'h4000_0000, 1'b0);
    push_pair(32'h8000_0000, 32'd1, 1'b0);
    push_pair(32'd1, 32'h8000_0000, 1'b0);
    push_pair(32'h0000_0000, 32'h8000_0000, 1'b0);
    push_pair(32'h1234_5678, 32'h1234_5678, 1'b0);
    push_pair(32'd3 << 20, 32'd9 << 25, 1'b0);
    push_pair(32'd4294967291, 32'd4294967279, 1'b0);
    push_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    push_pair(32'hFFFF_FFFE, 32'h7FFF_FFFF, 1'b0);
    push_pair(32'd1071, 32'd462, 1'b0);
    push_pair(32'd48, 32'd180, 1'b0);
    push_pair(32'd2, 32'd0, 1'b0);

    // random pairs, with runs of back-to-back items
    quiet = 1'b0;
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 50 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 30) begin
        a = $urandom;
        b = $urandom;
      end else if (r < 60) begin
        g = word_t'($urandom_range(1, 65535)) << $urandom_range(0, 12);
        a = g * word_t'($urandom_range(1, 32'hFFFF_FFFF / g));
        b = g * word_t'($urandom_range(1, 32'hFFFF_FFFF / g));
      end else if (r < 75) begin
        a = pow2_heavy();
        b = pow2_heavy();
      end else if (r < 85) begin
        a = ($urandom_range(0, 2) == 0) ? '0 : word_t'($urandom);
        b = (a != '0 && $urandom_range(0, 1) == 0) ? '0 : word_t'($urandom);
      end else if (r < 90) begin
        a = $urandom;
        b = a;
      end else begin
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end
      push_pair(a, b, quiet);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // sample between edges so that queue and valid updates have settled
    do begin
      @(negedge clk);
    end while (pair_q.size() != 0 || in_valid || gcd_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== binary_gcd_core.f =====
+incdir+sv
sv/bgcd_pkg.sv
sv/bgcd_cell.sv
sv/bgcd_chain.sv
sv/binary_gcd_core.sv
verif/tb_binary_gcd_core.sv
